### hdl/gjd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian / Julian Day Number converter package
// Shared widths, calendar constants, reciprocal multipliers and month tables.
// ----------------------------------------------------------------------------
package gjd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int JDN_W   = 23;
    localparam int WDAY_W  = 3;

    localparam int NSTAGE      = 7;
    localparam int TO_STAGES   = 4;
    localparam int FROM_STAGES = 6;

    localparam logic [JDN_W-1:0]   JDN_FIRST = 23'd1721426;
    localparam logic [JDN_W-1:0]   JDN_LAST  = 23'd5373484;
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
    localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;

    localparam int EPOCH_YEAR    = 4800;
    localparam int EPOCH_CENT    = 48;
    localparam int JDN_BIAS      = 32045;
    localparam int JDN_BIAS_REV  = 32044;
    localparam int X1_BIAS       = 4 * JDN_BIAS_REV + 3;
    localparam int DAYS_PER_YEAR = 365;
    localparam int DAYS_PER_400Y = 146097;
    localparam int DAYS_PER_4Y   = 1461;
    localparam int DAYS_PER_5M   = 153;
    localparam int WEEK_DAYS     = 7;

    // x / d == (x * ceil(2^sh / d)) >> sh, exact for x below 2^(sh - ceil(log2 d))
    localparam int Q100_SH    = 21;
    localparam int Q146097_SH = 44;
    localparam int Q1461_SH   = 29;
    localparam int Q153_SH    = 20;
    localparam int Q7_SH      = 26;

    localparam logic [14:0] REC_100 =
        15'(((64'd1 << Q100_SH) + 64'd99) / 64'd100);
    localparam logic [26:0] REC_146097 =
        27'(((64'd1 << Q146097_SH) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y));
    localparam logic [18:0] REC_1461 =
        19'(((64'd1 << Q1461_SH) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));
    localparam logic [12:0] REC_153 =
        13'(((64'd1 << Q153_SH) + 64'(DAYS_PER_5M) - 64'd1) / 64'(DAYS_PER_5M));
    localparam logic [23:0] REC_7 =
        24'(((64'd1 << Q7_SH) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

    typedef struct packed {
        logic               func;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [JDN_W-1:0]   jdn;
    } item_t;

    function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] month,
                                             input logic leap);
        logic [4:0] len;
        len = 5'd31;
        case (month) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            default:                len = 5'd31;
        endcase
        return len;
    endfunction

    // days before a March-based month: (153 * mm + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] mm);
        logic [8:0] ofs;
        ofs = 9'd0;
        case (mm)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

### hdl/gregorian_julian_day_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date / Julian Day Number converter
// Converts a date to its day number (func 0) or a day number to its date
// (func 1), with weekday and range flag.
// ----------------------------------------------------------------------------
// Seven-stage pipeline: out_valid is the last stage's valid bit, and one word
// can enter every cycle while in_ready is high. The depth is set by the chain
// of reciprocal multiplies of the day-number decode (400-year and 4-year steps,
// each followed by a remainder stage, then the month step); the date encode
// runs alongside it in four stages, and the weekday fills the rest on the
// shared result. Every stage holds its own valid bit and advances on its own,
// so a stalled output only blocks the input once all seven stages are full.
module gregorian_julian_day_converter
    import gjd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               func,
    input  logic [YEAR_W-1:0]  year_in,
    input  logic [MONTH_W-1:0] month_in,
    input  logic [DAY_W-1:0]   day_in,
    input  logic [JDN_W-1:0]   day_number_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [JDN_W-1:0]   day_number_out,
    output logic [YEAR_W-1:0]  year_out,
    output logic [MONTH_W-1:0] month_out,
    output logic [DAY_W-1:0]   day_out,
    output logic [WDAY_W-1:0]  weekday,
    output logic               invalid
);

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] en;

    item_t             carry_reg [0:NSTAGE-2];
    item_t             item_next;

    logic [JDN_W-1:0]  to_jdn;
    logic              to_bad;
    logic [YEAR_W-1:0] from_year;
    logic [MONTH_W-1:0] from_month;
    logic [DAY_W-1:0]  from_day;
    logic              from_bad;

    logic [JDN_W-1:0]  num5_reg, num5_next;
    logic              bad5_reg;
    logic [JDN_W-1:0]  num6_reg;
    logic [20:0]       q7_reg, q7_next;
    logic              bad6_reg;
    logic [46:0]       prod7;

    logic [JDN_W-1:0]   day_number_out_reg;
    logic [YEAR_W-1:0]  year_out_reg, year_out_next;
    logic [MONTH_W-1:0] month_out_reg, month_out_next;
    logic [DAY_W-1:0]   day_out_reg, day_out_next;
    logic [WDAY_W-1:0]  weekday_reg, weekday_next;
    logic               invalid_reg, invalid_next;

    // a stage loads when it is empty or its word moves on
    always_comb
    begin
        en[NSTAGE-1] = !valid_reg[NSTAGE-1] || out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NSTAGE-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        item_next.func  = func;
        item_next.year  = year_in;
        item_next.month = month_in;
        item_next.day   = day_in;
        item_next.jdn   = day_number_in;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            carry_reg[0] <= item_next;
        end
        for (int k = 1; k < NSTAGE - 1; k++)
        begin
            if (en[k])
            begin
                carry_reg[k] <= carry_reg[k-1];
            end
        end
    end

    gjd_to_jdn u_to_jdn (
        .clk   (clk),
        .en    (en[TO_STAGES-1:0]),
        .year  (year_in),
        .month (month_in),
        .day   (day_in),
        .jdn   (to_jdn),
        .bad   (to_bad)
    );

    gjd_from_jdn u_from_jdn (
        .clk   (clk),
        .en    (en[FROM_STAGES-1:0]),
        .jdn   (day_number_in),
        .year  (from_year),
        .month (from_month),
        .day   (from_day),
        .bad   (from_bad)
    );

    // weekday: day number mod 7 plus 1
    always_comb
    begin
        num5_next = carry_reg[TO_STAGES-1].func ? carry_reg[TO_STAGES-1].jdn : to_jdn;
        prod7     = 47'(num5_reg) * 47'(REC_7);
        q7_next   = prod7[Q7_SH +: 21];
        weekday_next = WDAY_W'(24'(num6_reg) - 24'(q7_reg) * 24'(WEEK_DAYS)) + 3'd1;
    end

    always_comb
    begin
        if (carry_reg[NSTAGE-2].func)
        begin
            year_out_next  = from_year;
            month_out_next = from_month;
            day_out_next   = from_day;
            invalid_next   = from_bad;
        end
        else
        begin
            year_out_next  = carry_reg[NSTAGE-2].year;
            month_out_next = carry_reg[NSTAGE-2].month;
            day_out_next   = carry_reg[NSTAGE-2].day;
            invalid_next   = bad6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            num5_reg <= num5_next;
            bad5_reg <= to_bad;
        end
        if (en[5])
        begin
            num6_reg <= num5_reg;
            q7_reg   <= q7_next;
            bad6_reg <= bad5_reg;
        end
        if (en[6])
        begin
            day_number_out_reg <= num6_reg;
            year_out_reg       <= year_out_next;
            month_out_reg      <= month_out_next;
            day_out_reg        <= day_out_next;
            weekday_reg        <= weekday_next;
            invalid_reg        <= invalid_next;
        end
    end

    assign day_number_out = day_number_out_reg;
    assign year_out       = year_out_reg;
    assign month_out      = month_out_reg;
    assign day_out        = day_out_reg;
    assign weekday        = weekday_reg;
    assign invalid        = invalid_reg;

endmodule

### hdl/gjd_to_jdn.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Date to day number pipeline
// Four stages: century split, date check and March shift, partial sums, final
// sum. Invalid dates give day number zero.
// ----------------------------------------------------------------------------
module gjd_to_jdn
    import gjd_pkg::*;
(
    input  logic                 clk,
    input  logic [TO_STAGES-1:0] en,
    input  logic [YEAR_W-1:0]    year,
    input  logic [MONTH_W-1:0]   month,
    input  logic [DAY_W-1:0]     day,
    output logic [JDN_W-1:0]     jdn,
    output logic                 bad
);

    // stage A
    logic [YEAR_W-1:0]  year_a_reg;
    logic [MONTH_W-1:0] month_a_reg;
    logic [DAY_W-1:0]   day_a_reg;
    logic [7:0]         q100_a_reg, q100_a_next;
    logic [28:0]        prod_a;

    // stage B
    logic               bad_b_reg, bad_b_next;
    logic [14:0]        yy_b_reg, yy_b_next;
    logic [7:0]         yq_b_reg, yq_b_next;
    logic [3:0]         mm_b_reg, mm_b_next;
    logic [DAY_W-1:0]   day_b_reg;
    logic [13:0]        hund;
    logic               cent, leap, shift;

    // stage C
    logic [23:0]        party_c_reg, party_c_next;
    logic [8:0]         partm_c_reg, partm_c_next;
    logic [7:0]         yq_c_reg;
    logic               bad_c_reg;

    // stage D
    logic [JDN_W-1:0]   jdn_reg, jdn_next;
    logic               bad_reg;

    always_comb
    begin
        prod_a      = 29'(year) * 29'(REC_100);
        q100_a_next = prod_a[Q100_SH +: 8];
    end

    always_comb
    begin
        hund  = 14'(q100_a_reg) * 14'd100;
        cent  = (year_a_reg == hund);
        leap  = (year_a_reg[1:0] == 2'b00) && (!cent || (q100_a_reg[1:0] == 2'b00));
        shift = (month_a_reg <= 4'd2);
        mm_b_next = shift ? (month_a_reg + 4'd9) : (month_a_reg - 4'd3);
        yy_b_next = 15'(year_a_reg) + 15'(EPOCH_YEAR) - 15'(shift);
        yq_b_next = 8'(EPOCH_CENT) + q100_a_reg - 8'(shift && cent);
        bad_b_next = (year_a_reg == '0) || (year_a_reg > YEAR_MAX)
                  || (month_a_reg == '0) || (month_a_reg > MONTH_MAX)
                  || (day_a_reg == '0)
                  || (5'(day_a_reg) > month_len(month_a_reg, leap));
    end

    always_comb
    begin
        party_c_next = 24'(yy_b_reg) * 24'(DAYS_PER_YEAR) + 24'(yy_b_reg >> 2)
                     - 24'(JDN_BIAS);
        partm_c_next = month_offset(mm_b_reg) + 9'(day_b_reg) + 9'(yq_b_reg >> 2);
    end

    always_comb
    begin
        if (bad_c_reg)
        begin
            jdn_next = '0;
        end
        else
        begin
            jdn_next = JDN_W'(party_c_reg + 24'(partm_c_reg) - 24'(yq_c_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            year_a_reg  <= year;
            month_a_reg <= month;
            day_a_reg   <= day;
            q100_a_reg  <= q100_a_next;
        end
        if (en[1])
        begin
            bad_b_reg <= bad_b_next;
            yy_b_reg  <= yy_b_next;
            yq_b_reg  <= yq_b_next;
            mm_b_reg  <= mm_b_next;
            day_b_reg <= day_a_reg;
        end
        if (en[2])
        begin
            party_c_reg <= party_c_next;
            partm_c_reg <= partm_c_next;
            yq_c_reg    <= yq_b_reg;
            bad_c_reg   <= bad_b_reg;
        end
        if (en[3])
        begin
            jdn_reg <= jdn_next;
            bad_reg <= bad_c_reg;
        end
    end

    assign jdn = jdn_reg;
    assign bad = bad_reg;

endmodule

### hdl/gjd_from_jdn.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day number to date pipeline
// Six stages: a bias step, then reciprocal divide and remainder steps
// (400-year cycle, 4-year cycle, month); the date is assembled from the last
// stage. Out-of-range day numbers give year, month and day zero.
// ----------------------------------------------------------------------------
module gjd_from_jdn
    import gjd_pkg::*;
(
    input  logic                   clk,
    input  logic [FROM_STAGES-1:0] en,
    input  logic [JDN_W-1:0]       jdn,
    output logic [YEAR_W-1:0]      year,
    output logic [MONTH_W-1:0]     month,
    output logic [DAY_W-1:0]       day,
    output logic                   bad
);

    // bad flag travels with each stage
    logic [FROM_STAGES-1:0] bad_reg;
    logic                   bad_next;

    logic [25:0] x1_a_reg, x1_a_next;
    logic [25:0] x1_b_reg;
    logic [8:0]  b_b_reg, b_b_next;
    logic [52:0] prod_b;

    logic [17:0] x2_c_reg, x2_c_next;
    logic [8:0]  b_c_reg;
    logic [26:0] bprod_c;
    logic [17:0] r1_c;

    logic [17:0] x2_d_reg;
    logic [7:0]  e4_d_reg, e4_d_next;
    logic [8:0]  b_d_reg;
    logic [36:0] prod_d;

    logic [8:0]  e_e_reg, e_e_next;
    logic [11:0] x3_e_reg, x3_e_next;
    logic [7:0]  e4_e_reg;
    logic [8:0]  b_e_reg;
    logic [10:0] r2_e;

    logic [4:0]  mm_f_reg, mm_f_next;
    logic [8:0]  e_f_reg;
    logic [7:0]  e4_f_reg;
    logic [8:0]  b_f_reg;
    logic [24:0] prod_f;

    logic        wrap;

    always_comb
    begin
        bad_next  = (jdn < JDN_FIRST) || (jdn > JDN_LAST);
        x1_a_next = {1'b0, jdn, 2'b00} + 26'(X1_BIAS);
    end

    always_comb
    begin
        prod_b   = 53'(x1_a_reg) * 53'(REC_146097);
        b_b_next = prod_b[Q146097_SH +: 9];
    end

    always_comb
    begin
        bprod_c   = 27'(b_b_reg) * 27'(DAYS_PER_400Y);
        r1_c      = 18'(27'(x1_b_reg) - bprod_c);
        x2_c_next = {r1_c[17:2], 2'b11};
    end

    always_comb
    begin
        prod_d    = 37'(x2_c_reg) * 37'(REC_1461);
        e4_d_next = prod_d[Q1461_SH +: 8];
    end

    always_comb
    begin
        r2_e      = 11'(19'(x2_d_reg) - 19'(e4_d_reg) * 19'(DAYS_PER_4Y));
        e_e_next  = r2_e[10:2];
        x3_e_next = 12'(e_e_next) * 12'd5 + 12'd2;
    end

    always_comb
    begin
        prod_f    = 25'(x3_e_reg) * 25'(REC_153);
        mm_f_next = prod_f[Q153_SH +: 5];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x1_a_reg   <= x1_a_next;
            bad_reg[0] <= bad_next;
        end
        if (en[1])
        begin
            x1_b_reg   <= x1_a_reg;
            b_b_reg    <= b_b_next;
            bad_reg[1] <= bad_reg[0];
        end
        if (en[2])
        begin
            x2_c_reg   <= x2_c_next;
            b_c_reg    <= b_b_reg;
            bad_reg[2] <= bad_reg[1];
        end
        if (en[3])
        begin
            x2_d_reg   <= x2_c_reg;
            e4_d_reg   <= e4_d_next;
            b_d_reg    <= b_c_reg;
            bad_reg[3] <= bad_reg[2];
        end
        if (en[4])
        begin
            e_e_reg    <= e_e_next;
            x3_e_reg   <= x3_e_next;
            e4_e_reg   <= e4_d_reg;
            b_e_reg    <= b_d_reg;
            bad_reg[4] <= bad_reg[3];
        end
        if (en[5])
        begin
            mm_f_reg   <= mm_f_next;
            e_f_reg    <= e_e_reg;
            e4_f_reg   <= e4_e_reg;
            b_f_reg    <= b_e_reg;
            bad_reg[5] <= bad_reg[4];
        end
    end

    // January and February close the March-based year
    always_comb
    begin
        wrap = (mm_f_reg >= 5'd10);
        if (bad_reg[FROM_STAGES-1])
        begin
            year  = '0;
            month = '0;
            day   = '0;
        end
        else
        begin
            day   = DAY_W'(e_f_reg - month_offset(mm_f_reg[3:0]) + 9'd1);
            month = wrap ? MONTH_W'(mm_f_reg - 5'd9) : MONTH_W'(mm_f_reg + 5'd3);
            year  = YEAR_W'(17'(b_f_reg) * 17'd100 + 17'(e4_f_reg) + 17'(wrap)
                          - 17'(EPOCH_YEAR));
        end
    end

    assign bad = bad_reg[FROM_STAGES-1];

endmodule
